// ===== design/dpt_pkg.sv =====
// Package for the detection persistence tracker.
// Holds store sizes, field widths, event and state codes and the
// command and status structs shared by the controller and the datapath.
package dpt_pkg;

  localparam int TRACK_DEPTH = 16;
  localparam int FRAME_DEPTH = 16;
  localparam int SHOWN_DEPTH = 16;
  localparam int COORD_BITS  = 12;

  localparam int TRACK_IDX_W = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
  localparam int FRAME_IDX_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int SHOWN_IDX_W = (SHOWN_DEPTH > 1) ? $clog2(SHOWN_DEPTH) : 1;
  localparam int TRACK_CNT_W = $clog2(TRACK_DEPTH + 1);
  localparam int FRAME_CNT_W = $clog2(FRAME_DEPTH + 1);
  localparam int SHOWN_CNT_W = $clog2(SHOWN_DEPTH + 1);
  localparam int SCAN_W      = (FRAME_CNT_W > SHOWN_CNT_W) ? FRAME_CNT_W : SHOWN_CNT_W;

  localparam int MARGIN_W    = 12;
  localparam int THR_W       = 8;
  localparam int COUNT_W     = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET    = 12'd20;
  localparam logic [THR_W-1:0]    THRESHOLD_RESET = 8'd10;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMP_POINT,
    CMP_FRAME,
    CMP_SHOWN
  } cmp_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PSCAN,
    S_PFRAME,
    S_PFRAME_INS,
    S_PEMIT,
    S_ECHK,
    S_EFRM,
    S_ESHN,
    S_EDEL,
    S_EDONE
  } state_t;

  typedef struct packed {
    cmp_sel_t cmp_sel;
    logic     load_in;
    logic     i_clr;
    logic     i_inc;
    logic     j_clr;
    logic     track_append;
    logic     count_inc;
    logic     shown_append;
    logic     frame_append;
    logic     acc_frame;
    logic     acc_shown;
    logic     compact;
    logic     eof_finish;
    logic     emit;
    kind_t    emit_kind;
    logic     emit_last;
  } cmd_t;

  typedef struct packed {
    logic has_point;
    logic end_of_frame;
    logic i_end;
    logic j_frame_end;
    logic j_shown_end;
    logic near;
    logic count_below;
    logic count_hits;
    logic count_zero;
    logic seen;
    logic shown;
    logic out_free;
  } sts_t;

endpackage

// ===== design/dpt_channels.sv =====
// Channel interfaces of the detection persistence tracker.
// Uses dpt_pkg for coordinate widths.
interface dpt_point_if;
  logic                         valid;
  logic                         ready;
  logic [dpt_pkg::COORD_BITS-1:0] point_x;
  logic [dpt_pkg::COORD_BITS-1:0] point_y;
  logic                         has_point;
  logic                         end_of_frame;

  modport source(output valid, point_x, point_y, has_point, end_of_frame, input ready);
  modport sink(input valid, point_x, point_y, has_point, end_of_frame, output ready);
endinterface

interface dpt_event_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   event_kind;
  logic [dpt_pkg::COORD_BITS-1:0] event_x;
  logic [dpt_pkg::COORD_BITS-1:0] event_y;
  logic                         overflow;
  logic                         last;

  modport source(output valid, event_kind, event_x, event_y, overflow, last, input ready);
  modport sink(input valid, event_kind, event_x, event_y, overflow, last, output ready);
endinterface

// ===== design/dpt_ctrl.sv =====
// Controller state machine of the detection persistence tracker.
// Sequences the point scan and the frame-end sweep; depends on dpt_pkg.
module dpt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dpt_pkg::sts_t sts,
  output dpt_pkg::cmd_t cmd
);

  dpt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.cmp_sel  = dpt_pkg::CMP_POINT;
    cmd.emit_kind = dpt_pkg::KIND_DONE;
    in_ready     = 1'b0;
    unique case (state)
      dpt_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_next = dpt_pkg::S_DISPATCH;
      end
      dpt_pkg::S_DISPATCH: begin
        cmd.i_clr = 1'b1;
        if (sts.has_point) state_next = dpt_pkg::S_PSCAN;
        else if (sts.end_of_frame) state_next = dpt_pkg::S_ECHK;
        else state_next = dpt_pkg::S_IDLE;
      end
      dpt_pkg::S_PSCAN: begin
        cmd.cmp_sel = dpt_pkg::CMP_POINT;
        if (sts.i_end) begin
          cmd.track_append = 1'b1;
          state_next = dpt_pkg::S_PFRAME;
        end else if (sts.near) begin
          // A count at or above the threshold absorbs the hit unchanged.
          cmd.count_inc = sts.count_below;
          if (sts.count_below && sts.count_hits) begin
            cmd.shown_append = 1'b1;
            state_next = dpt_pkg::S_PFRAME_INS;
          end else begin
            state_next = dpt_pkg::S_PFRAME;
          end
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      dpt_pkg::S_PFRAME: begin
        cmd.frame_append = 1'b1;
        cmd.i_clr = 1'b1;
        state_next = sts.end_of_frame ? dpt_pkg::S_ECHK : dpt_pkg::S_IDLE;
      end
      dpt_pkg::S_PFRAME_INS: begin
        cmd.frame_append = 1'b1;
        state_next = dpt_pkg::S_PEMIT;
      end
      dpt_pkg::S_PEMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = dpt_pkg::KIND_INSERT;
        cmd.emit_last = !sts.end_of_frame;
        if (sts.out_free) begin
          cmd.i_clr = 1'b1;
          state_next = sts.end_of_frame ? dpt_pkg::S_ECHK : dpt_pkg::S_IDLE;
        end
      end
      dpt_pkg::S_ECHK: begin
        if (sts.i_end) begin
          cmd.eof_finish = 1'b1;
          state_next = dpt_pkg::S_EDONE;
        end else begin
          cmd.j_clr = 1'b1;
          state_next = dpt_pkg::S_EFRM;
        end
      end
      dpt_pkg::S_EFRM: begin
        cmd.cmp_sel = dpt_pkg::CMP_FRAME;
        if (!sts.j_frame_end) begin
          cmd.acc_frame = 1'b1;
        end else if (!sts.seen && sts.count_zero) begin
          cmd.j_clr = 1'b1;
          state_next = dpt_pkg::S_ESHN;
        end else begin
          cmd.compact = 1'b1;
          cmd.i_inc   = 1'b1;
          state_next  = dpt_pkg::S_ECHK;
        end
      end
      dpt_pkg::S_ESHN: begin
        cmd.cmp_sel = dpt_pkg::CMP_SHOWN;
        if (!sts.j_shown_end) begin
          cmd.acc_shown = 1'b1;
        end else if (sts.shown) begin
          state_next = dpt_pkg::S_EDEL;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = dpt_pkg::S_ECHK;
        end
      end
      dpt_pkg::S_EDEL: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = dpt_pkg::KIND_DELETE;
        if (sts.out_free) begin
          cmd.i_inc  = 1'b1;
          state_next = dpt_pkg::S_ECHK;
        end
      end
      dpt_pkg::S_EDONE: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = dpt_pkg::KIND_DONE;
        cmd.emit_last = 1'b1;
        if (sts.out_free) state_next = dpt_pkg::S_IDLE;
      end
      default: state_next = dpt_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== design/dpt_datapath.sv =====
// Datapath of the detection persistence tracker: track, frame and shown
// stores, scan counters, the shared proximity compare and the result register.
// Driven by dpt_ctrl through dpt_pkg::cmd_t; depends on dpt_pkg.
module dpt_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  dpt_pkg::coord_t                   in_x,
  input  dpt_pkg::coord_t                   in_y,
  input  logic                              in_has,
  input  logic                              in_eof,
  input  dpt_pkg::cmd_t                     cmd,
  output dpt_pkg::sts_t                     sts,
  output logic                              ev_valid,
  input  logic                              ev_ready,
  output logic [1:0]                        ev_kind,
  output dpt_pkg::coord_t                   ev_x,
  output dpt_pkg::coord_t                   ev_y,
  output logic                              ev_overflow,
  output logic                              ev_last
);

  dpt_pkg::coord_t                    px, py;
  logic                               has, eof;
  logic [dpt_pkg::MARGIN_W-1:0]       margin;
  logic [dpt_pkg::THR_W-1:0]          threshold;
  logic                               overflow_flag;

  dpt_pkg::coord_t                    track_x [dpt_pkg::TRACK_DEPTH];
  dpt_pkg::coord_t                    track_y [dpt_pkg::TRACK_DEPTH];
  dpt_pkg::count_t                    track_count [dpt_pkg::TRACK_DEPTH];
  logic [dpt_pkg::TRACK_CNT_W-1:0]    track_used;
  dpt_pkg::coord_t                    frame_x [dpt_pkg::FRAME_DEPTH];
  dpt_pkg::coord_t                    frame_y [dpt_pkg::FRAME_DEPTH];
  logic [dpt_pkg::FRAME_CNT_W-1:0]    frame_fill;
  dpt_pkg::coord_t                    shown_x [dpt_pkg::SHOWN_DEPTH];
  dpt_pkg::coord_t                    shown_y [dpt_pkg::SHOWN_DEPTH];
  logic [dpt_pkg::SHOWN_CNT_W-1:0]    shown_fill;

  logic [dpt_pkg::TRACK_CNT_W-1:0]    i, w;
  logic [dpt_pkg::SCAN_W-1:0]         j;
  logic                               seen, shown;

  dpt_pkg::coord_t                    cur_x, cur_y, cmp_x, cmp_y, dx, dy;
  dpt_pkg::count_t                    cur_cnt;
  logic [dpt_pkg::COUNT_W:0]          cnt_plus;
  logic                               near, out_free;

  assign cur_x   = track_x[i[dpt_pkg::TRACK_IDX_W-1:0]];
  assign cur_y   = track_y[i[dpt_pkg::TRACK_IDX_W-1:0]];
  assign cur_cnt = track_count[i[dpt_pkg::TRACK_IDX_W-1:0]];

  always_comb begin
    unique case (cmd.cmp_sel)
      dpt_pkg::CMP_FRAME: begin
        cmp_x = frame_x[j[dpt_pkg::FRAME_IDX_W-1:0]];
        cmp_y = frame_y[j[dpt_pkg::FRAME_IDX_W-1:0]];
      end
      dpt_pkg::CMP_SHOWN: begin
        cmp_x = shown_x[j[dpt_pkg::SHOWN_IDX_W-1:0]];
        cmp_y = shown_y[j[dpt_pkg::SHOWN_IDX_W-1:0]];
      end
      default: begin
        cmp_x = px;
        cmp_y = py;
      end
    endcase
  end

  // Strict per-axis window: |a - b| < margin on both axes.
  assign dx   = (cur_x >= cmp_x) ? (cur_x - cmp_x) : (cmp_x - cur_x);
  assign dy   = (cur_y >= cmp_y) ? (cur_y - cmp_y) : (cmp_y - cur_y);
  assign near = (dx < margin) && (dy < margin);

  assign cnt_plus = {1'b0, cur_cnt} + {{dpt_pkg::COUNT_W{1'b0}}, 1'b1};
  assign out_free = !ev_valid || ev_ready;

  always_comb begin
    sts.has_point    = has;
    sts.end_of_frame = eof;
    sts.i_end        = (i == track_used);
    sts.j_frame_end  = (j == dpt_pkg::SCAN_W'(frame_fill));
    sts.j_shown_end  = (j == dpt_pkg::SCAN_W'(shown_fill));
    sts.near         = near;
    sts.count_below  = (cur_cnt < threshold);
    sts.count_hits   = (cnt_plus == {1'b0, threshold});
    sts.count_zero   = (cur_cnt == '0);
    sts.seen         = seen;
    sts.shown        = shown;
    sts.out_free     = out_free;
  end

  // Configuration and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      margin        <= dpt_pkg::MARGIN_RESET;
      threshold     <= dpt_pkg::THRESHOLD_RESET;
      overflow_flag <= 1'b0;
      track_used    <= '0;
      frame_fill    <= '0;
      shown_fill    <= '0;
      i             <= '0;
      w             <= '0;
      j             <= '0;
      seen          <= 1'b0;
      shown         <= 1'b0;
      ev_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dpt_pkg::CFG_MARGIN:    margin    <= cfg_data[dpt_pkg::MARGIN_W-1:0];
          dpt_pkg::CFG_THRESHOLD: threshold <= cfg_data[dpt_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.track_append) begin
        if (track_used < dpt_pkg::TRACK_CNT_W'(dpt_pkg::TRACK_DEPTH)) begin
          track_used <= track_used + dpt_pkg::TRACK_CNT_W'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.shown_append) begin
        if (shown_fill < dpt_pkg::SHOWN_CNT_W'(dpt_pkg::SHOWN_DEPTH)) begin
          shown_fill <= shown_fill + dpt_pkg::SHOWN_CNT_W'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.frame_append) begin
        if (frame_fill < dpt_pkg::FRAME_CNT_W'(dpt_pkg::FRAME_DEPTH)) begin
          frame_fill <= frame_fill + dpt_pkg::FRAME_CNT_W'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.eof_finish) begin
        track_used <= w;
        frame_fill <= '0;
      end
      if (cmd.i_clr) begin
        i <= '0;
        w <= '0;
      end else begin
        if (cmd.i_inc) i <= i + dpt_pkg::TRACK_CNT_W'(1);
        if (cmd.compact) w <= w + dpt_pkg::TRACK_CNT_W'(1);
      end
      if (cmd.j_clr) begin
        j     <= '0;
        seen  <= 1'b0;
        shown <= 1'b0;
      end else if (cmd.acc_frame || cmd.acc_shown) begin
        j <= j + dpt_pkg::SCAN_W'(1);
        if (cmd.acc_frame && near) seen <= 1'b1;
        if (cmd.acc_shown && near) shown <= 1'b1;
      end
      if (cmd.emit && out_free) begin
        ev_valid <= 1'b1;
      end else if (ev_ready) begin
        ev_valid <= 1'b0;
      end
    end
  end

  // Payload registers and stores.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      px  <= in_x;
      py  <= in_y;
      has <= in_has;
      eof <= in_eof;
    end
    if (cmd.track_append && track_used < dpt_pkg::TRACK_CNT_W'(dpt_pkg::TRACK_DEPTH)) begin
      track_x[track_used[dpt_pkg::TRACK_IDX_W-1:0]]     <= px;
      track_y[track_used[dpt_pkg::TRACK_IDX_W-1:0]]     <= py;
      track_count[track_used[dpt_pkg::TRACK_IDX_W-1:0]] <= dpt_pkg::COUNT_W'(1);
    end else if (cmd.count_inc) begin
      track_count[i[dpt_pkg::TRACK_IDX_W-1:0]] <= cnt_plus[dpt_pkg::COUNT_W-1:0];
    end else if (cmd.compact) begin
      // Survivors slide down to keep the valid entries a prefix in arrival order.
      track_x[w[dpt_pkg::TRACK_IDX_W-1:0]]     <= cur_x;
      track_y[w[dpt_pkg::TRACK_IDX_W-1:0]]     <= cur_y;
      track_count[w[dpt_pkg::TRACK_IDX_W-1:0]] <=
        cur_cnt - {{(dpt_pkg::COUNT_W-1){1'b0}}, !seen};
    end
    if (cmd.shown_append && shown_fill < dpt_pkg::SHOWN_CNT_W'(dpt_pkg::SHOWN_DEPTH)) begin
      shown_x[shown_fill[dpt_pkg::SHOWN_IDX_W-1:0]] <= cur_x;
      shown_y[shown_fill[dpt_pkg::SHOWN_IDX_W-1:0]] <= cur_y;
    end
    if (cmd.frame_append && frame_fill < dpt_pkg::FRAME_CNT_W'(dpt_pkg::FRAME_DEPTH)) begin
      frame_x[frame_fill[dpt_pkg::FRAME_IDX_W-1:0]] <= px;
      frame_y[frame_fill[dpt_pkg::FRAME_IDX_W-1:0]] <= py;
    end
    if (cmd.emit && out_free) begin
      ev_kind     <= cmd.emit_kind;
      ev_x        <= (cmd.emit_kind == dpt_pkg::KIND_DONE) ? '0 : cur_x;
      ev_y        <= (cmd.emit_kind == dpt_pkg::KIND_DONE) ? '0 : cur_y;
      ev_overflow <= overflow_flag;
      ev_last     <= cmd.emit_last;
    end
  end

endmodule

// ===== design/detection_persistence_tracker_unit.sv =====
// Top level of the detection persistence tracker.
// Joins dpt_ctrl and dpt_datapath; depends on dpt_pkg and dpt_channels.
//
// Usage: detected points arrive on the points channel, one per transfer,
// and the last item of a camera frame has end_of_frame set. Events leave on
// the events channel: insert when a tracked point reaches the threshold,
// delete when a decayed entry near a shown device is dropped, and frame
// done after each frame end. last marks the final event of an item.
// margin and threshold are written through cfg_we, cfg_index and cfg_data.
// One item is processed at a time; points.ready is high only while idle.
// A point is compared with the tracked entries in order up to the first
// match or is appended as a new entry; it also goes into the frame store,
// with an insert event when the count reaches the threshold. A frame end
// compares each tracked entry with the frame points and, for a dropped
// entry, with the shown points (a delete if one is near), then emits the
// done event. The stores are scanned serially with one proximity compare.
// Reset clears all tracking, the fill counts and the overflow flag and
// restores margin 20 and threshold 10. Events sit in one output register;
// when the receiver stalls, the controller waits to load the next event.
module detection_persistence_tracker_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpt_pkg::CFG_DATA_W-1:0]  cfg_data,
  dpt_point_if.sink                       points,
  dpt_event_if.source                     events
);

  dpt_pkg::cmd_t cmd;
  dpt_pkg::sts_t sts;
  logic          ready;

  assign points.ready = ready;

  dpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_x        (points.point_x),
    .in_y        (points.point_y),
    .in_has      (points.has_point),
    .in_eof      (points.end_of_frame),
    .cmd         (cmd),
    .sts         (sts),
    .ev_valid    (events.valid),
    .ev_ready    (events.ready),
    .ev_kind     (events.event_kind),
    .ev_x        (events.event_x),
    .ev_y        (events.event_y),
    .ev_overflow (events.overflow),
    .ev_last     (events.last)
  );

endmodule

// ===== design/dpt_checker.sv =====
// Port-level checker for the detection persistence tracker, bound to the
// top level. Depends on dpt_pkg for event codes.
module dpt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         ev_valid,
  input logic                         ev_ready,
  input logic [1:0]                   ev_kind,
  input logic [dpt_pkg::COORD_BITS-1:0] ev_x,
  input logic [dpt_pkg::COORD_BITS-1:0] ev_y,
  input logic                         ev_overflow,
  input logic                         ev_last
);

  logic overflow_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (ev_valid && ev_ready && ev_overflow) begin
      overflow_seen <= 1'b1;
    end
  end

  // Frame done closes the item and carries no coordinates.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_kind == dpt_pkg::KIND_DONE |-> ev_last && ev_x == '0 && ev_y == '0)
    else $error("frame done event malformed");

  // Only the three event codes appear.
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> ev_kind == dpt_pkg::KIND_INSERT || ev_kind == dpt_pkg::KIND_DELETE ||
                 ev_kind == dpt_pkg::KIND_DONE)
    else $error("unknown event code");

  // The overflow flag never falls once reported.
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    ev_valid && overflow_seen |-> ev_overflow)
    else $error("overflow flag dropped");

  // While an item still owes events, no new item is taken.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_last |-> !in_ready)
    else $error("input taken while item unfinished");

  // An input transfer is followed in the next cycle by not ready.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back input transfer");

endmodule

bind detection_persistence_tracker_unit dpt_checker u_dpt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (points.valid),
  .in_ready    (points.ready),
  .ev_valid    (events.valid),
  .ev_ready    (events.ready),
  .ev_kind     (events.event_kind),
  .ev_x        (events.event_x),
  .ev_y        (events.event_y),
  .ev_overflow (events.overflow),
  .ev_last     (events.last)
);

// ===== tb/sv/detection_persistence_tracker_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench for detection_persistence_tracker_unit: directed and random point frames
// are checked against an in-bench tracking predictor. Depends on dpt_pkg,
// dpt_channels and the block itself.
module detection_persistence_tracker_unit_tb;

  typedef struct {
    dpt_pkg::kind_t  kind;
    dpt_pkg::coord_t x;
    dpt_pkg::coord_t y;
    logic            ovf;
    logic            last;
  } track_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index = dpt_pkg::CFG_MARGIN;
  logic [dpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  dpt_point_if pts();
  dpt_event_if evs();

  detection_persistence_tracker_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .points(pts), .events(evs)
  );

  always #4 clk = ~clk;

  // Predictor state.
  dpt_pkg::coord_t  trk_x[dpt_pkg::TRACK_DEPTH], trk_y[dpt_pkg::TRACK_DEPTH];
  dpt_pkg::count_t  trk_cnt[dpt_pkg::TRACK_DEPTH];
  int               trk_n;
  dpt_pkg::coord_t  frm_x[dpt_pkg::FRAME_DEPTH], frm_y[dpt_pkg::FRAME_DEPTH];
  int               frm_n;
  dpt_pkg::coord_t  shw_x[dpt_pkg::SHOWN_DEPTH], shw_y[dpt_pkg::SHOWN_DEPTH];
  int               shw_n;
  logic             ovf_flag;
  logic [dpt_pkg::MARGIN_W-1:0] cur_margin = dpt_pkg::MARGIN_RESET;
  logic [dpt_pkg::THR_W-1:0]    cur_thr = dpt_pkg::THRESHOLD_RESET;

  track_event_t pending_events[$];
  int errors = 0;
  bit idle_en = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  initial begin
    pts.valid = 1'b0;
    pts.point_x = '0;
    pts.point_y = '0;
    pts.has_point = 1'b0;
    pts.end_of_frame = 1'b0;
    evs.ready = 1'b0;
    trk_n = 0;
    frm_n = 0;
    shw_n = 0;
    ovf_flag = 1'b0;
  end

  function automatic bit axis_close(dpt_pkg::coord_t a, dpt_pkg::coord_t b);
    int d, m;
    d = int'(a) - int'(b);
    m = int'(cur_margin);
    return d > -m && d < m;
  endfunction

  function automatic bit pt_close(dpt_pkg::coord_t ax, dpt_pkg::coord_t ay,
                                  dpt_pkg::coord_t bx, dpt_pkg::coord_t by);
    return axis_close(ax, bx) && axis_close(ay, by);
  endfunction

  function automatic void push_event(dpt_pkg::kind_t k, dpt_pkg::coord_t x,
                                     dpt_pkg::coord_t y);
    track_event_t e;
    e.kind = k;
    e.x = x;
    e.y = y;
    e.ovf = ovf_flag;
    e.last = 1'b0;
    pending_events.push_back(e);
  endfunction

  // Works out the events caused by one accepted item and updates the tracking state.
  function automatic void predict_tracking(dpt_pkg::coord_t px, dpt_pkg::coord_t py,
                                           logic has, logic eof);
    int base, i, j, w;
    bit hit, seen, shown;
    base = pending_events.size();
    if (has) begin
      hit = 0;
      for (i = 0; i < trk_n; i++) begin
        if (pt_close(px, py, trk_x[i], trk_y[i])) begin
          hit = 1;
          if (trk_cnt[i] < cur_thr) begin
            trk_cnt[i] = trk_cnt[i] + 8'd1;
            if (trk_cnt[i] == cur_thr) begin
              if (shw_n < dpt_pkg::SHOWN_DEPTH) begin
                shw_x[shw_n] = trk_x[i];
                shw_y[shw_n] = trk_y[i];
                shw_n++;
              end else begin
                ovf_flag = 1'b1;
              end
              push_event(dpt_pkg::KIND_INSERT, trk_x[i], trk_y[i]);
            end
          end
          break;
        end
      end
      if (!hit) begin
        if (trk_n < dpt_pkg::TRACK_DEPTH) begin
          trk_x[trk_n] = px;
          trk_y[trk_n] = py;
          trk_cnt[trk_n] = 8'd1;
          trk_n++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      if (frm_n < dpt_pkg::FRAME_DEPTH) begin
        frm_x[frm_n] = px;
        frm_y[frm_n] = py;
        frm_n++;
      end else begin
        ovf_flag = 1'b1;
      end
      // The insert event reports the flag as it stands after the whole point.
      if (pending_events.size() > base)
        pending_events[pending_events.size()-1].ovf = ovf_flag;
    end
    if (eof) begin
      w = 0;
      for (i = 0; i < trk_n; i++) begin
        seen = 0;
        for (j = 0; j < frm_n; j++)
          if (pt_close(trk_x[i], trk_y[i], frm_x[j], frm_y[j])) seen = 1;
        if (!seen && trk_cnt[i] == 0) begin
          shown = 0;
          for (j = 0; j < shw_n; j++)
            if (pt_close(trk_x[i], trk_y[i], shw_x[j], shw_y[j])) shown = 1;
          if (shown) push_event(dpt_pkg::KIND_DELETE, trk_x[i], trk_y[i]);
          continue;
        end
        if (!seen) trk_cnt[i] = trk_cnt[i] - 8'd1;
        trk_x[w] = trk_x[i];
        trk_y[w] = trk_y[i];
        trk_cnt[w] = trk_cnt[i];
        w++;
      end
      trk_n = w;
      frm_n = 0;
      push_event(dpt_pkg::KIND_DONE, '0, '0);
    end
    if (pending_events.size() > base)
      pending_events[pending_events.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Receiver: random stall bursts and the event check.
  always @(posedge clk) begin
    track_event_t e;
    if (rst) begin
      evs.ready <= 1'b0;
    end else begin
      if (evs.valid && evs.ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch("unexpected event kind", evs.event_kind, -1);
        end else begin
          e = pending_events.pop_front();
          if (evs.event_kind !== e.kind) report_mismatch("event_kind", evs.event_kind, e.kind);
          if (evs.event_x !== e.x) report_mismatch("event_x", evs.event_x, e.x);
          if (evs.event_y !== e.y) report_mismatch("event_y", evs.event_y, e.y);
          if (evs.overflow !== e.ovf) report_mismatch("overflow", evs.overflow, e.ovf);
          if (evs.last !== e.last) report_mismatch("last", evs.last, e.last);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        evs.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 15);
        evs.ready <= 1'b0;
      end else begin
        evs.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((pts.valid && pts.ready) || (evs.valid && evs.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(dpt_pkg::coord_t x, dpt_pkg::coord_t y, logic has, logic eof);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      pts.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    pts.point_x <= x;
    pts.point_y <= y;
    pts.has_point <= has;
    pts.end_of_frame <= eof;
    pts.valid <= 1'b1;
    do @(posedge clk); while (!pts.ready);
    predict_tracking(x, y, has, eof);
  endtask

  // Stops sending and waits until every expected event has come and the block is idle.
  task automatic drain_events();
    pts.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_config(logic [dpt_pkg::CFG_IDX_W-1:0] idx, int value);
    drain_events();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[dpt_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dpt_pkg::CFG_MARGIN) cur_margin = value[dpt_pkg::MARGIN_W-1:0];
    else cur_thr = value[dpt_pkg::THR_W-1:0];
  endtask

  task automatic test_defaults();
    send_item(12'd0, 12'd0, 1'b1, 1'b0);
    send_item(12'd4095, 12'd4095, 1'b1, 1'b0);
    send_item(12'd1234, 12'd2345, 1'b0, 1'b0);
    send_item(12'd0, 12'd0, 1'b0, 1'b1);
    // A device seen in every frame reaches the default threshold of ten.
    repeat (10) begin
      send_item(12'd100, 12'd200, 1'b1, 1'b0);
      send_item(12'd4095, 12'd0, 1'b1, 1'b1);
    end
  endtask

  task automatic test_config_extremes();
    write_config(dpt_pkg::CFG_MARGIN, 1);
    write_config(dpt_pkg::CFG_THRESHOLD, 1);
    send_item(12'd500, 12'd500, 1'b1, 1'b0);
    send_item(12'd501, 12'd500, 1'b1, 1'b0);
    send_item(12'd500, 12'd500, 1'b1, 1'b1);
    write_config(dpt_pkg::CFG_MARGIN, 4095);
    write_config(dpt_pkg::CFG_THRESHOLD, 255);
    send_item(12'd0, 12'd4095, 1'b1, 1'b1);
    send_item(12'd0, 12'd0, 1'b0, 1'b1);
    // Empty frames decay everything; deletes follow for shown devices.
    repeat (3) send_item(12'd0, 12'd0, 1'b0, 1'b1);
  endtask

  task automatic test_overflow();
    write_config(dpt_pkg::CFG_MARGIN, 4);
    write_config(dpt_pkg::CFG_THRESHOLD, 2);
    for (int i = 0; i < 18; i++)
      send_item(dpt_pkg::coord_t'(i * 200), dpt_pkg::coord_t'(4000 - i * 200), 1'b1, i == 17);
    for (int i = 0; i < 17; i++)
      send_item(dpt_pkg::coord_t'(i * 200), dpt_pkg::coord_t'(4000 - i * 200), 1'b1, i == 16);
  endtask

  task automatic run_random_frames(int n_items, int mrg, int thr);
    dpt_pkg::coord_t dev_x[6], dev_y[6];
    int sent, k, pts_in_frame;
    dpt_pkg::coord_t x, y;
    write_config(dpt_pkg::CFG_MARGIN, mrg);
    write_config(dpt_pkg::CFG_THRESHOLD, thr);
    foreach (dev_x[i]) begin
      dev_x[i] = dpt_pkg::coord_t'($urandom_range(0, 4095));
      dev_y[i] = dpt_pkg::coord_t'($urandom_range(0, 4095));
    end
    sent = 0;
    while (sent < n_items) begin
      pts_in_frame = $urandom_range(0, 5);
      for (int p = 0; p <= pts_in_frame; p++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(dpt_pkg::coord_t'($urandom), dpt_pkg::coord_t'($urandom), 1'b0, 1'b0);
        if ($urandom_range(0, 4) == 0) begin
          x = dpt_pkg::coord_t'($urandom);
          y = dpt_pkg::coord_t'($urandom);
        end else begin
          k = $urandom_range(0, 5);
          x = dpt_pkg::coord_t'(int'(dev_x[k]) + $urandom_range(0, 16) - 8);
          y = dpt_pkg::coord_t'(int'(dev_y[k]) + $urandom_range(0, 16) - 8);
        end
        // The last item of a frame is sometimes an empty frame end.
        if (p == pts_in_frame && $urandom_range(0, 3) == 0)
          send_item(x, y, 1'b0, 1'b1);
        else
          send_item(x, y, 1'b1, p == pts_in_frame);
        sent++;
      end
    end
  endtask

  task automatic test_random();
    run_random_frames(30, 20, 3);
    run_random_frames(25, 300, 2);
    drain_events();
    run_random_frames(25, 1, 1);
    run_random_frames(25, 4095, 255);
    run_random_frames(25, 12, 4);
  endtask

  task automatic test_no_idle();
    drain_events();
    idle_en = 1'b0;
    run_random_frames(25, 16, 2);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_config_extremes();
    test_overflow();
    test_random();
    test_no_idle();
    drain_events();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== detection_persistence_tracker_unit.f =====
design/dpt_pkg.sv
design/dpt_channels.sv
design/dpt_ctrl.sv
design/dpt_datapath.sv
design/detection_persistence_tracker_unit.sv
design/dpt_checker.sv
tb/sv/detection_persistence_tracker_unit_tb.sv
